### design/nst_pkg.sv
// ----------------------------------------------------------------------------
// nst_pkg
// Shared types, constants and the key normalisation function for the
// named slot table store.
// ----------------------------------------------------------------------------
package nst_pkg;

	localparam int NAME_BYTES = 8;
	localparam int KEY_W      = 8 * NAME_BYTES;
	localparam int VAL_W      = 32;
	localparam int SLOTS      = 9;
	localparam int SLOT_W     = 4;
	localparam logic [SLOT_W-1:0] SLOT_LIM  = SLOT_W'(SLOTS);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		MODE_SET = 2'd0,
		MODE_GET = 2'd1,
		MODE_DEL = 2'd2,
		MODE_NOP = 2'd3
	} nst_mode_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_ACT,
		ST_RDWAIT,
		ST_ZERO,
		ST_RESP
	} nst_state_t;

	typedef struct packed {
		logic [1:0]              mode;
		logic [KEY_W-1:0]        key;
		logic [SLOT_W-1:0]       slot;
		logic signed [VAL_W-1:0] wval;
	} nst_req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [VAL_W-1:0] read_value;
	} nst_resp_t;

	typedef struct packed {
		logic clearing;
		logic idle;
	} nst_status_t;

	// Zero every byte from the first zero byte upwards.
	function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] r;
		logic             seen;
		r    = '0;
		seen = 1'b0;
		for (int i = 0; i < NAME_BYTES; i++) begin
			if (k[8*i +: 8] == 8'd0) begin
				seen = 1'b1;
			end
			if (!seen) begin
				r[8*i +: 8] = k[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

### design/nst_key_ram.sv
// ----------------------------------------------------------------------------
// nst_key_ram
// Name memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module nst_key_ram #(
	parameter int ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  logic [nst_pkg::KEY_W-1:0]  wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output logic [nst_pkg::KEY_W-1:0]  rdata
);
	import nst_pkg::*;

	logic [KEY_W-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/nst_slot_ram.sv
// ----------------------------------------------------------------------------
// nst_slot_ram
// Slot value memory: single port, registered read data.
// ----------------------------------------------------------------------------
module nst_slot_ram #(
	parameter int DEPTH = 576
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic                              re,
	input  logic [$clog2(DEPTH)-1:0]          addr,
	input  logic signed [nst_pkg::VAL_W-1:0]  wdata,
	output logic signed [nst_pkg::VAL_W-1:0]  rdata
);
	import nst_pkg::*;

	logic signed [VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### design/nst_ctrl.sv
// ----------------------------------------------------------------------------
// nst_ctrl
// Sequencer: reset sweep of the name memory, match/free scan, then slot
// read, slot write, entry delete or entry allocation.
// ----------------------------------------------------------------------------
module nst_ctrl #(
	parameter int ENTRIES = 64
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   req_valid,
	input  nst_pkg::nst_req_t                      req,
	output nst_pkg::nst_status_t                   status,
	output logic                                   resp_valid,
	input  logic                                   resp_ready,
	output nst_pkg::nst_resp_t                     resp,
	output logic                                   key_we,
	output logic [$clog2(ENTRIES)-1:0]             key_waddr,
	output logic [nst_pkg::KEY_W-1:0]              key_wdata,
	output logic                                   key_re,
	output logic [$clog2(ENTRIES)-1:0]             key_raddr,
	input  logic [nst_pkg::KEY_W-1:0]              key_rdata,
	output logic                                   slot_we,
	output logic                                   slot_re,
	output logic [$clog2(ENTRIES*nst_pkg::SLOTS)-1:0] slot_addr,
	output logic signed [nst_pkg::VAL_W-1:0]       slot_wdata,
	input  logic signed [nst_pkg::VAL_W-1:0]       slot_rdata
);
	import nst_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int SA_W  = $clog2(ENTRIES * SLOTS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);
	localparam logic [IDX_W:0]   ISS_END  = (IDX_W+1)'(ENTRIES);

	nst_state_t              state_q, state_d;
	logic [IDX_W-1:0]        clr_q;
	logic [IDX_W:0]          iss_q;
	logic                    cmp_vld_s1;
	logic [IDX_W-1:0]        cmp_idx_s1;
	logic                    free_fnd_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic [IDX_W-1:0]        tgt_q;
	logic [SLOT_W-1:0]       zc_q;
	nst_mode_t               mode_q;
	logic [KEY_W-1:0]        key_q;
	logic [SLOT_W-1:0]       slot_q;
	logic signed [VAL_W-1:0] wval_q;
	logic                    ok_q;
	logic signed [VAL_W-1:0] rv_q;

	logic [KEY_W-1:0]        norm_key;
	logic                    hit;
	logic                    is_free;
	logic                    last;
	logic                    free_any;
	logic                    slot_in;
	logic [SLOT_W-1:0]       sel_slot;
	logic [IDX_W+3:0]        slot_sum;

	assign norm_key = normalize_key(req.key);
	assign hit      = cmp_vld_s1 && (key_rdata == key_q);
	assign is_free  = cmp_vld_s1 && (key_rdata == '0);
	assign last     = cmp_vld_s1 && (cmp_idx_s1 == IDX_LAST);
	assign free_any = free_fnd_q || is_free;
	assign slot_in  = slot_q < SLOT_LIM;

	// entry base is index times nine
	assign sel_slot = (state_q == ST_ZERO) ? zc_q : slot_q;
	assign slot_sum = {1'b0, tgt_q, 3'b000} + {4'b0000, tgt_q} + {{IDX_W{1'b0}}, sel_slot};
	assign slot_addr = slot_sum[SA_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDX_LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					if (req.mode == MODE_NOP || norm_key == '0) state_d = ST_RESP;
					else state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) state_d = ST_ACT;
				else if (last) state_d = (mode_q == MODE_SET && free_any) ? ST_ZERO : ST_RESP;
			end
			ST_ACT: begin
				if (mode_q == MODE_GET && slot_in) state_d = ST_RDWAIT;
				else state_d = ST_RESP;
			end
			ST_RDWAIT: state_d = ST_RESP;
			ST_ZERO: begin
				if (zc_q == SLOT_LAST) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (resp_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		key_we     = 1'b0;
		key_waddr  = tgt_q;
		key_wdata  = '0;
		key_re     = 1'b0;
		key_raddr  = iss_q[IDX_W-1:0];
		slot_we    = 1'b0;
		slot_re    = 1'b0;
		slot_wdata = wval_q;
		status     = '{clearing: 1'b0, idle: 1'b0};
		resp_valid = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				status.clearing = 1'b1;
				key_we          = 1'b1;
				key_waddr       = clr_q;
			end
			ST_IDLE: status.idle = 1'b1;
			ST_SCAN: key_re = iss_q < ISS_END;
			ST_ACT: begin
				slot_we = (mode_q == MODE_SET) && slot_in;
				slot_re = (mode_q == MODE_GET) && slot_in;
				key_we  = (mode_q == MODE_DEL);
			end
			ST_RDWAIT: ;
			ST_ZERO: begin
				slot_we    = 1'b1;
				slot_wdata = (zc_q == slot_q) ? wval_q : '0;
				key_we     = (zc_q == '0);
				key_wdata  = key_q;
			end
			ST_RESP: resp_valid = 1'b1;
			default: ;
		endcase
	end

	assign resp = '{ok: ok_q, read_value: rv_q};

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			iss_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			free_fnd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (state_q == ST_IDLE) begin
				iss_q      <= '0;
				cmp_vld_s1 <= 1'b0;
				free_fnd_q <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				if (key_re) iss_q <= iss_q + 1'b1;
				cmp_vld_s1 <= key_re && (state_d == ST_SCAN);
				if (is_free) free_fnd_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			mode_q <= nst_mode_t'(req.mode);
			key_q  <= norm_key;
			slot_q <= req.slot;
			wval_q <= req.wval;
			ok_q   <= 1'b0;
			rv_q   <= '0;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= iss_q[IDX_W-1:0];
			if (is_free && !free_fnd_q) free_idx_q <= cmp_idx_s1;
			zc_q <= '0;
			if (hit) begin
				tgt_q <= cmp_idx_s1;
				ok_q  <= 1'b1;
			end else if (last && mode_q == MODE_SET && free_any) begin
				tgt_q <= free_fnd_q ? free_idx_q : cmp_idx_s1;
				ok_q  <= 1'b1;
			end
		end
		if (state_q == ST_ZERO) zc_q <= zc_q + 1'b1;
		if (state_q == ST_RDWAIT) rv_q <= slot_rdata;
	end

endmodule

### design/named_slot_table_store_unit.sv
// ----------------------------------------------------------------------------
// named_slot_table_store_unit - keyed table of named entries, nine slots each
// Throughput: one transaction at a time, the scan reading one entry a cycle;
// the next is taken once the result has moved to the output register.
// Reset: a sweep clears the name memory; slots are zeroed when an entry is
// allocated.
// ----------------------------------------------------------------------------
module named_slot_table_store_unit #(
	parameter int ENTRIES = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        mode,
	input  logic [nst_pkg::KEY_W-1:0]         key,
	input  logic [nst_pkg::SLOT_W-1:0]        slot,
	input  logic signed [nst_pkg::VAL_W-1:0]  write_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              ok,
	output logic signed [nst_pkg::VAL_W-1:0]  read_value
);
	import nst_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int SA_W  = $clog2(ENTRIES * SLOTS);

	// Request and response travel as structs between the top and the sequencer.
	nst_req_t    req;
	nst_resp_t   resp;
	nst_status_t status;
	logic        resp_valid;
	logic        resp_ready;

	// Name memory port
	logic                    key_we;
	logic [IDX_W-1:0]        key_waddr;
	logic [KEY_W-1:0]        key_wdata;
	logic                    key_re;
	logic [IDX_W-1:0]        key_raddr;
	logic [KEY_W-1:0]        key_rdata;

	// Slot memory port
	logic                    slot_we;
	logic                    slot_re;
	logic [SA_W-1:0]         slot_addr;
	logic signed [VAL_W-1:0] slot_wdata;
	logic signed [VAL_W-1:0] slot_rdata;

	// Output register
	logic                    out_valid_q;
	logic                    ok_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic                    load;

	assign req = '{mode: mode, key: key, slot: slot, wval: write_value};

	// A new transaction is taken whenever the sequencer is idle, even with a
	// finished result still parked in the output register.
	assign in_ready = status.idle;

	nst_ctrl #(
		.ENTRIES(ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req       (req),
		.status    (status),
		.resp_valid(resp_valid),
		.resp_ready(resp_ready),
		.resp      (resp),
		.key_we    (key_we),
		.key_waddr (key_waddr),
		.key_wdata (key_wdata),
		.key_re    (key_re),
		.key_raddr (key_raddr),
		.key_rdata (key_rdata),
		.slot_we   (slot_we),
		.slot_re   (slot_re),
		.slot_addr (slot_addr),
		.slot_wdata(slot_wdata),
		.slot_rdata(slot_rdata)
	);

	nst_key_ram #(
		.ENTRIES(ENTRIES)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (key_re),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

	nst_slot_ram #(
		.DEPTH(ENTRIES * SLOTS)
	) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.re   (slot_re),
		.addr (slot_addr),
		.wdata(slot_wdata),
		.rdata(slot_rdata)
	);

	// Result register: refilled when empty or being drained this cycle.
	assign resp_ready = !out_valid_q || out_ready;
	assign load       = resp_valid && resp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ok_q         <= resp.ok;
			read_value_q <= resp.read_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign read_value = read_value_q;

`ifndef SYNTHESIS
	// No transaction is taken during the post-reset clearing sweep.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		status.clearing |-> !in_ready)
		else $error("input taken during clearing sweep");

	// A pending response means the sequencer is busy with its transaction.
	a_resp_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid |-> !in_ready)
		else $error("input ready while response pending");

	// One transaction at a time: accepting one closes the input next cycle.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("back-to-back accept");

	// A result only appears after the sequencer offered it.
	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(resp_valid))
		else $error("result without response");
`endif

endmodule

### dv/table_mirror_pkg.sv
// ----------------------------------------------------------------------------
// table_mirror_pkg
// Scoreboard for the named slot table store. It keeps its own copy of the
// name and slot tables and the queue of answers still owed by the unit.
// ----------------------------------------------------------------------------
package table_mirror_pkg;

	import nst_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct {
		logic                    ok;
		logic signed [VAL_W-1:0] rval;
	} table_answer_t;

	class table_mirror;

		logic [KEY_W-1:0]        name_tbl [TABLE_DEPTH];
		logic signed [VAL_W-1:0] slot_tbl [TABLE_DEPTH][SLOTS];
		table_answer_t           due_answers [$];
		int                      errors;

		function new();
			foreach (name_tbl[i]) begin
				name_tbl[i] = '0;
				for (int s = 0; s < SLOTS; s++) slot_tbl[i][s] = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return due_answers.size();
		endfunction

		// Apply one accepted request to the mirror and queue the answer it owes.
		function void note_request(logic [1:0] op, logic [KEY_W-1:0] key_in,
					   logic [SLOT_W-1:0] slot_no, logic signed [VAL_W-1:0] wval);
			logic [KEY_W-1:0] name;
			int               hit;
			table_answer_t    ans;
			// bytes past the first zero byte do not count
			name = key_in;
			for (int b = 0; b < NAME_BYTES; b++) begin
				if (key_in[8*b +: 8] == 8'h00) begin
					name = key_in & ((64'h1 << (8 * b)) - 64'h1);
					break;
				end
			end
			hit = -1;
			if (name != '0) begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (name_tbl[i] == name) begin
						hit = i;
						break;
					end
				end
			end
			ans.ok   = 1'b0;
			ans.rval = '0;
			case (nst_mode_t'(op))
				MODE_SET: begin
					if (name != '0) begin
						if (hit < 0) begin
							for (int i = 0; i < TABLE_DEPTH; i++) begin
								if (name_tbl[i] == '0) begin
									hit         = i;
									name_tbl[i] = name;
									break;
								end
							end
						end
						if (hit >= 0) begin
							if (slot_no < SLOTS) slot_tbl[hit][slot_no] = wval;
							ans.ok = 1'b1;
						end
					end
				end
				MODE_GET: begin
					if (hit >= 0) begin
						ans.ok = 1'b1;
						if (slot_no < SLOTS) ans.rval = slot_tbl[hit][slot_no];
					end
				end
				MODE_DEL: begin
					if (hit >= 0) begin
						name_tbl[hit] = '0;
						for (int s = 0; s < SLOTS; s++) slot_tbl[hit][s] = '0;
						ans.ok = 1'b1;
					end
				end
				default: ;
			endcase
			due_answers.push_back(ans);
		endfunction

		// Compare one accepted answer with the oldest one owed.
		function void check_answer(logic ok_got, logic signed [VAL_W-1:0] rval_got);
			table_answer_t ans;
			if (due_answers.size() == 0) begin
				errors++;
				if (errors < 40)
					$error("unexpected answer: ok %0d read_value %0d", ok_got, rval_got);
				return;
			end
			ans = due_answers.pop_front();
			if (ok_got !== ans.ok) begin
				errors++;
				if (errors < 40)
					$error("ok: expected %0d, got %0d", ans.ok, ok_got);
			end
			if (rval_got !== ans.rval) begin
				errors++;
				if (errors < 40)
					$error("read_value: expected %0d, got %0d", ans.rval, rval_got);
			end
		endfunction

	endclass

endpackage

### dv/tb_named_slot_table_store_unit.sv
// ----------------------------------------------------------------------------
// tb_named_slot_table_store_unit
// Drives set, get and delete transactions into the table store and checks
// every answer against a mirror of the table. A short directed run covers
// empty and aliased names, out-of-range slots and the unused mode; the random
// run keeps the table near full so that allocation failures come often.
// ----------------------------------------------------------------------------
module tb_named_slot_table_store_unit;

	timeunit 1ns;
	timeprecision 1ps;

	import nst_pkg::*;
	import table_mirror_pkg::*;

	localparam int RANDOM_ITEMS = 1875;
	localparam int CALM_TAIL    = 150;   // final stretch with no idling at all
	localparam int NAME_POOL    = 96;    // more names than entries, so it fills
	localparam int STUCK_LIMIT  = 4000;  // cycles with no transaction on either side

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               mode;
	logic [KEY_W-1:0]         key;
	logic [SLOT_W-1:0]        slot;
	logic signed [VAL_W-1:0]  write_value;
	logic                     out_valid;
	logic                     out_ready;
	logic                     ok;
	logic signed [VAL_W-1:0]  read_value;

	logic                     no_gaps;
	int                       stall_left;
	int                       stuck_cycles;
	logic [KEY_W-1:0]         pool_name [NAME_POOL];
	int                       pool_len  [NAME_POOL];

	table_mirror sb = new();

	named_slot_table_store_unit #(
		.ENTRIES(TABLE_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.key        (key),
		.slot       (slot),
		.write_value(write_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.ok         (ok),
		.read_value (read_value)
	);

	always #2 clk = ~clk;

	// Monitor: both channels sampled on the rising edge. Requests are noted
	// before answers are checked; a request can be taken in the same cycle
	// as an earlier answer leaves the output register.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_request(mode, key, slot, write_value);
			if (out_valid && out_ready)
				sb.check_answer(ok, read_value);
		end
	end

	// Watchdog: a hung handshake on either side ends the run. The limit
	// covers the clearing sweep after reset plus a full miss-and-allocate.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver back-pressure: random bursts with ready low,
	// switched off during the calm stretches.
	always @(negedge clk) begin
		if (no_gaps) begin
			out_ready  = 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready = 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready  = 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			out_ready = 1'b1;
		end
	end

	// Present one transaction from a falling edge and hold it until taken.
	// Returns on the falling edge after acceptance with valid still high, so
	// back-to-back transactions drop valid only for a random gap in between.
	task automatic send(input logic [1:0] op, input logic [KEY_W-1:0] name,
			    input logic [SLOT_W-1:0] slot_no, input logic signed [VAL_W-1:0] wval);
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid    = 1'b1;
		mode        = op;
		key         = name;
		slot        = slot_no;
		write_value = wval;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Hold off the sender until every owed answer has come back.
	task automatic drain();
		in_valid = 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// A name from the pool; short names sometimes carry rubbish after their
	// terminating zero byte, which must alias to the clean name.
	function automatic logic [KEY_W-1:0] pick_name();
		int               i;
		logic [KEY_W-1:0] k;
		i = $urandom_range(0, NAME_POOL - 1);
		k = pool_name[i];
		if (pool_len[i] < NAME_BYTES - 1 && $urandom_range(0, 1) == 1) begin
			for (int b = pool_len[i] + 1; b < NAME_BYTES; b++)
				k[8*b +: 8] = 8'($urandom_range(0, 255));
		end
		return k;
	endfunction

	initial begin
		nst_mode_t               op;
		int                      roll;
		logic [KEY_W-1:0]        name;
		logic [SLOT_W-1:0]       slot_no;
		logic signed [VAL_W-1:0] wval;

		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_SET;
		key          = '0;
		slot         = '0;
		write_value  = '0;
		out_ready    = 1'b0;
		no_gaps      = 1'b0;
		stall_left   = 0;
		stuck_cycles = 0;

		// name pool: lengths 1..8, every name byte non-zero, at least a quarter full length
		for (int i = 0; i < NAME_POOL; i++) begin
			pool_len[i]  = ($urandom_range(0, 3) == 0) ? NAME_BYTES : $urandom_range(1, NAME_BYTES);
			pool_name[i] = '0;
			for (int b = 0; b < pool_len[i]; b++)
				pool_name[i][8*b +: 8] = 8'($urandom_range(1, 255));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed part ---
		// empty table, then the zero name in every guise
		send(MODE_GET, 64'h41, 4'd0, 32'sd0);
		send(MODE_SET, 64'h0, 4'd1, 32'sd7);
		send(MODE_SET, 64'hFFFF_FFFF_FFFF_FF00, 4'd2, 32'sd9);   // zero first byte
		send(MODE_GET, 64'h0, 4'd0, 32'sd0);
		send(MODE_DEL, 64'h0, 4'd0, 32'sd0);
		// full-length name, extreme values and slots
		send(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sh7FFF_FFFF);
		send(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'sh8000_0000);
		send(MODE_SET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, -32'sd1);  // slot ignored
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sd0);
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'sd0);
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 32'sd0);
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'sd0);
		// short name with rubbish after the terminator, then its aliases
		send(MODE_SET, 64'hDEAD_BEEF_0000_4241, 4'd3, 32'sh1234_5678);
		send(MODE_GET, 64'h0000_0000_0000_4241, 4'd3, 32'sd0);
		send(MODE_GET, 64'h0000_FFFF_FF00_4241, 4'd3, 32'sd0);
		// unused mode leaves the table untouched
		send(MODE_NOP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sd1);
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sd0);
		// delete via an alias, then miss, then reuse the freed entry
		send(MODE_DEL, 64'h0000_5555_0000_4241, 4'd0, 32'sd0);
		send(MODE_GET, 64'h0000_0000_0000_4241, 4'd3, 32'sd0);
		send(MODE_DEL, 64'h0000_0000_0000_4241, 4'd0, 32'sd0);
		send(MODE_SET, 64'h0000_0000_0000_4241, 4'd3, 32'sd5);
		send(MODE_GET, 64'h0000_0000_0000_4241, 4'd0, 32'sd0);  // freshly cleared
		send(MODE_SET, 64'h01, 4'd4, 32'sd0);
		send(MODE_DEL, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sd0);
		send(MODE_GET, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'sd0);
		drain();

		// --- random part ---
		// Sets outweigh deletes over a pool larger than the table, so the
		// table spends most of the run full, with deletes punching holes.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			no_gaps = (n >= RANDOM_ITEMS - CALM_TAIL) || ((n / 120) % 5 == 4);
			if (n == RANDOM_ITEMS / 2) drain();

			roll = $urandom_range(0, 99);
			if (roll < 45)      op = MODE_SET;
			else if (roll < 80) op = MODE_GET;
			else if (roll < 95) op = MODE_DEL;
			else                op = MODE_NOP;

			roll = $urandom_range(0, 99);
			if (roll < 90)      name = pick_name();
			else if (roll < 96) name = {$urandom, $urandom};
			else                name = {$urandom, $urandom} & ~64'hFF;

			slot_no = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
							      : 4'($urandom_range(9, 15));

			roll = $urandom_range(0, 15);
			if (roll == 0)      wval = 32'sh7FFF_FFFF;
			else if (roll == 1) wval = 32'sh8000_0000;
			else                wval = $urandom;

			send(op, name, slot_no, wval);
		end
		in_valid = 1'b0;

		// wait for the last answers, then a margin to catch stray ones
		while (sb.pending() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
design/nst_pkg.sv
design/nst_key_ram.sv
design/nst_slot_ram.sv
design/nst_ctrl.sv
design/named_slot_table_store_unit.sv
dv/table_mirror_pkg.sv
dv/tb_named_slot_table_store_unit.sv
